// File: hdl/srgb_pkg.sv
// Shared constants, register codes and types for the sorted row group boundary block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package srgb_pkg;

    localparam int NUM_COLUMNS = 4;
    localparam int POS_BITS    = 31;
    localparam int KEY_W       = 64;
    localparam int LANE_LAT    = 6;
    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 64;
    localparam int COLS_W      = 3;

    localparam logic [1:0] REG_TOL  = 2'd0;
    localparam logic [1:0] REG_MASK = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [KEY_W-1:0]    t_key;

    typedef struct packed {
        logic [KEY_W-1:0]       tol;
        logic [NUM_COLUMNS-1:0] real_mask;
        logic [COLS_W-1:0]      cols;
    } t_cfg;

endpackage

// File: hdl/srgb_ifs.sv
// Valid/ready channel interfaces for row beats in and result beats out.
// Depends on srgb_pkg for field widths.
`timescale 1ns / 1ps

interface srgb_row_if;
    logic               valid;
    logic               ready;
    srgb_pkg::t_key     key_col0;
    srgb_pkg::t_key     key_col1;
    srgb_pkg::t_key     key_col2;
    srgb_pkg::t_key     key_col3;
    logic               last_row;

    modport source(output valid, key_col0, key_col1, key_col2, key_col3, last_row,
                   input ready);
    modport sink(input valid, key_col0, key_col1, key_col2, key_col3, last_row,
                 output ready);
endinterface

interface srgb_res_if;
    logic               valid;
    logic               ready;
    logic               new_group;
    srgb_pkg::t_pos     row_position;
    logic               closed_group_valid;
    srgb_pkg::t_pos     closed_group_length;
    srgb_pkg::t_pos     final_group_length;

    modport source(output valid, new_group, row_position, closed_group_valid,
                   closed_group_length, final_group_length, input ready);
    modport sink(input valid, new_group, row_position, closed_group_valid,
                 closed_group_length, final_group_length, output ready);
endinterface

// File: hdl/sorted_row_group_boundaries_top.sv
// Throughput one row per cycle while result beats are taken. The input register feeds the
// six-stage double subtract and round in each column lane, and the result register follows
// the group logic.
// A result beat held by the sink stalls the whole pipeline and the row input with it.
// Synchronous active-low reset clears the pipeline valids, row counter, group start and
// configuration (columns in use resets to one). Depends on srgb_pkg, srgb_ifs and submodules.
`timescale 1ns / 1ps

module sorted_row_group_boundaries_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    srgb_row_if.sink                    i_row,
    srgb_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srgb_pkg::CFG_AW-1:0] paddr,
    input  logic [srgb_pkg::CFG_DW-1:0] pwdata,
    output logic [srgb_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    srgb_pkg::t_cfg w_cfg;
    logic           w_en;

    srgb_pkg::t_key r_prev [srgb_pkg::NUM_COLUMNS];
    srgb_pkg::t_key r_cur  [srgb_pkg::NUM_COLUMNS];
    srgb_pkg::t_key r_old  [srgb_pkg::NUM_COLUMNS];
    srgb_pkg::t_key w_in   [srgb_pkg::NUM_COLUMNS];
    logic           r_s0_vld, r_s0_last;
    logic           r_vld_p  [srgb_pkg::LANE_LAT];
    logic           r_last_p [srgb_pkg::LANE_LAT];
    logic [srgb_pkg::NUM_COLUMNS-1:0] w_ok;

    assign w_in[0]     = i_row.key_col0;
    assign w_in[1]     = i_row.key_col1;
    assign w_in[2]     = i_row.key_col2;
    assign w_in[3]     = i_row.key_col3;
    assign i_row.ready = w_en;

    srgb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            for (int i = 0; i < srgb_pkg::LANE_LAT; i++) begin
                r_vld_p[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_s0_vld   <= i_row.valid;
            r_vld_p[0] <= r_s0_vld;
            for (int i = 1; i < srgb_pkg::LANE_LAT; i++) begin
                r_vld_p[i] <= r_vld_p[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_last   <= i_row.last_row;
            r_last_p[0] <= r_s0_last;
            for (int i = 1; i < srgb_pkg::LANE_LAT; i++) begin
                r_last_p[i] <= r_last_p[i-1];
            end
            if (i_row.valid) begin
                for (int j = 0; j < srgb_pkg::NUM_COLUMNS; j++) begin
                    r_cur[j]  <= w_in[j];
                    r_old[j]  <= r_prev[j];
                    r_prev[j] <= w_in[j];
                end
            end
        end
    end

    for (genvar j = 0; j < srgb_pkg::NUM_COLUMNS; j++) begin : g_lane
        srgb_real_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_a       (r_cur[j]),
            .i_b       (r_old[j]),
            .i_is_real (w_cfg.real_mask[j]),
            .i_tol     (w_cfg.tol),
            .o_ok      (w_ok[j])
        );
    end

    srgb_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_p[srgb_pkg::LANE_LAT-1]),
        .i_last  (r_last_p[srgb_pkg::LANE_LAT-1]),
        .i_ok    (w_ok),
        .i_cols  (w_cfg.cols),
        .o_en    (w_en),
        .o_res   (o_res)
    );

endmodule

// File: hdl/srgb_cfg.sv
// APB-style configuration registers: tolerance, real column mask, columns in use.
// Depends on srgb_pkg.
`timescale 1ns / 1ps

module srgb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srgb_pkg::CFG_AW-1:0] paddr,
    input  logic [srgb_pkg::CFG_DW-1:0] pwdata,
    output logic [srgb_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output srgb_pkg::t_cfg              o_cfg
);

    srgb_pkg::t_cfg r_cfg;
    logic [1:0]     w_idx;

    assign w_idx  = paddr[4:3];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tol       <= '0;
            r_cfg.real_mask <= '0;
            r_cfg.cols      <= srgb_pkg::COLS_W'(1);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                srgb_pkg::REG_TOL:  r_cfg.tol       <= pwdata;
                srgb_pkg::REG_MASK: r_cfg.real_mask <= pwdata[srgb_pkg::NUM_COLUMNS-1:0];
                srgb_pkg::REG_COLS: r_cfg.cols      <= pwdata[srgb_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            srgb_pkg::REG_TOL:  prdata = r_cfg.tol;
            srgb_pkg::REG_MASK: prdata = {{(srgb_pkg::CFG_DW-srgb_pkg::NUM_COLUMNS){1'b0}},
                                          r_cfg.real_mask};
            srgb_pkg::REG_COLS: prdata = {{(srgb_pkg::CFG_DW-srgb_pkg::COLS_W){1'b0}},
                                          r_cfg.cols};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/srgb_real_lane.sv
// One key column compare lane: exact match, or pipelined double |a-b| < tolerance.
// Six register stages: swap, align, add, leading zero count, normalize, round/compare.
// Depends on srgb_pkg.
`timescale 1ns / 1ps

module srgb_real_lane (
    input  logic           i_clk,
    input  logic           i_en,
    input  srgb_pkg::t_key i_a,
    input  srgb_pkg::t_key i_b,
    input  logic           i_is_real,
    input  srgb_pkg::t_key i_tol,
    output logic           o_ok
);

    // Stage 1
    logic        r1_eq, r1_spec, r1_sub;
    logic [10:0] r1_el, r1_sh;
    logic [52:0] r1_sigb, r1_sigs;
    logic        w_swap;
    srgb_pkg::t_key w_big, w_sml;
    logic [10:0] w_eb, w_es, w_ebe, w_ese;

    always_comb begin
        w_swap = i_b[62:0] > i_a[62:0];
        w_big  = w_swap ? i_b : i_a;
        w_sml  = w_swap ? i_a : i_b;
        w_eb   = w_big[62:52];
        w_es   = w_sml[62:52];
        w_ebe  = (w_eb == 11'd0) ? 11'd1 : w_eb;
        w_ese  = (w_es == 11'd0) ? 11'd1 : w_es;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_eq   <= (i_a == i_b);
            r1_spec <= (i_a[62:52] == 11'h7FF) || (i_b[62:52] == 11'h7FF);
            r1_sub  <= (i_a[63] == i_b[63]);
            r1_el   <= w_ebe;
            r1_sh   <= w_ebe - w_ese;
            r1_sigb <= {(w_eb != 11'd0), w_big[51:0]};
            r1_sigs <= {(w_es != 11'd0), w_sml[51:0]};
        end
    end

    // Stage 2: align the smaller operand, folding shifted-out bits into a sticky bit
    logic        r2_eq, r2_spec, r2_sub;
    logic [10:0] r2_el;
    logic [55:0] r2_big, r2_small;
    logic [55:0] w_ext, w_mask, n_small;

    always_comb begin
        w_ext  = {r1_sigs, 3'b000};
        w_mask = (56'd1 << r1_sh[5:0]) - 56'd1;
        if (r1_sh >= 11'd56) begin
            n_small = {55'd0, |r1_sigs};
        end else begin
            n_small = (w_ext >> r1_sh[5:0]) | {55'd0, |(w_ext & w_mask)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_eq    <= r1_eq;
            r2_spec  <= r1_spec;
            r2_sub   <= r1_sub;
            r2_el    <= r1_el;
            r2_big   <= {r1_sigb, 3'b000};
            r2_small <= n_small;
        end
    end

    // Stage 3: magnitude add or subtract
    logic        r3_eq, r3_spec;
    logic [10:0] r3_el;
    logic [56:0] r3_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_eq   <= r2_eq;
            r3_spec <= r2_spec;
            r3_el   <= r2_el;
            r3_r    <= r2_sub ? ({1'b0, r2_big} - {1'b0, r2_small})
                              : ({1'b0, r2_big} + {1'b0, r2_small});
        end
    end

    // Stage 4: leading zero count below the carry bit
    logic        r4_eq, r4_spec;
    logic [10:0] r4_el;
    logic [56:0] r4_r;
    logic [6:0]  r4_lz;
    logic [6:0]  n_lz;

    always_comb begin
        n_lz = 7'd56;
        for (int i = 0; i < 56; i++) begin
            if (r3_r[i]) begin
                n_lz = 7'(55 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_eq   <= r3_eq;
            r4_spec <= r3_spec;
            r4_el   <= r3_el;
            r4_r    <= r3_r;
            r4_lz   <= n_lz;
        end
    end

    // Stage 5: normalize, stopping at the smallest normal exponent
    logic        r5_eq, r5_spec;
    logic [10:0] r5_e;
    logic [55:0] r5_rn;
    logic [10:0] w_elm1, w_lz11, w_s;
    logic [10:0] n_e;
    logic [55:0] n_rn;

    always_comb begin
        w_elm1 = r4_el - 11'd1;
        w_lz11 = {4'd0, r4_lz};
        w_s    = (w_lz11 < w_elm1) ? w_lz11 : w_elm1;
        if (r4_r[56]) begin
            n_rn = {r4_r[56:2], r4_r[1] | r4_r[0]};
            n_e  = r4_el + 11'd1;
        end else begin
            n_rn = r4_r[55:0] << w_s[5:0];
            n_e  = r4_el - w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_eq   <= r4_eq;
            r5_spec <= r4_spec;
            r5_e    <= n_e;
            r5_rn   <= n_rn;
        end
    end

    // Stage 6: round to nearest even and compare against the tolerance
    logic        r6_ok;
    logic        w_inc, w_tol_nan, w_real_ok;
    logic [10:0] w_ef;
    logic [62:0] w_d;

    always_comb begin
        w_inc = r5_rn[2] && (r5_rn[1] || r5_rn[0] || r5_rn[3]);
        w_ef  = r5_rn[55] ? r5_e : 11'd0;
        if (r5_e == 11'h7FF) begin
            w_d = {11'h7FF, 52'd0};
        end else begin
            w_d = {w_ef, r5_rn[54:3]} + {62'd0, w_inc};
        end
        w_tol_nan = (i_tol[62:52] == 11'h7FF) && (i_tol[51:0] != 52'd0);
        w_real_ok = r5_eq || (!r5_spec && !i_tol[63] && !w_tol_nan && (w_d < i_tol[62:0]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ok <= i_is_real ? w_real_ok : r5_eq;
        end
    end

    assign o_ok = r6_ok;

endmodule

// File: hdl/srgb_group.sv
// Group tracking and result register: row counter, open group start, boundary lengths.
// Depends on srgb_pkg and srgb_ifs.
`timescale 1ns / 1ps

module srgb_group (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic                             i_last,
    input  logic [srgb_pkg::NUM_COLUMNS-1:0] i_ok,
    input  logic [srgb_pkg::COLS_W-1:0]      i_cols,
    output logic                             o_en,
    srgb_res_if.source                       o_res
);

    srgb_pkg::t_pos r_cnt, r_gstart;
    logic           r_out_vld;

    srgb_pkg::t_pos n_pos, n_gstart, w_clen, w_flen;
    logic [srgb_pkg::COLS_W-1:0] w_nc;
    logic w_first, w_match, w_ngrp, w_cvld;

    assign o_en        = !r_out_vld || o_res.ready;
    assign o_res.valid = r_out_vld;

    always_comb begin
        if (i_cols == '0) begin
            w_nc = srgb_pkg::COLS_W'(1);
        end else if (i_cols > srgb_pkg::COLS_W'(srgb_pkg::NUM_COLUMNS)) begin
            w_nc = srgb_pkg::COLS_W'(srgb_pkg::NUM_COLUMNS);
        end else begin
            w_nc = i_cols;
        end
        w_match = 1'b1;
        for (int j = 0; j < srgb_pkg::NUM_COLUMNS; j++) begin
            if ((srgb_pkg::COLS_W'(j) < w_nc) && !i_ok[j]) begin
                w_match = 1'b0;
            end
        end
        w_first  = (r_cnt == '0);
        n_pos    = (r_cnt < srgb_pkg::POS_MAX) ? r_cnt + 1'b1 : r_cnt;
        w_ngrp   = w_first || !w_match;
        w_cvld   = !w_first && !w_match;
        w_clen   = w_cvld ? n_pos - r_gstart : '0;
        n_gstart = w_ngrp ? n_pos : r_gstart;
        w_flen   = i_last ? n_pos - n_gstart + 1'b1 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_gstart  <= '0;
            r_out_vld <= 1'b0;
        end else if (o_en) begin
            r_out_vld <= i_vld;
            if (i_vld) begin
                r_cnt    <= i_last ? '0 : n_pos;
                r_gstart <= i_last ? '0 : n_gstart;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_vld) begin
            o_res.new_group           <= w_ngrp;
            o_res.row_position        <= n_pos;
            o_res.closed_group_valid  <= w_cvld;
            o_res.closed_group_length <= w_clen;
            o_res.final_group_length  <= w_flen;
        end
    end

endmodule
